>>> hdl/scpc_pkg.sv
// Shared types, codes and constants of the soft-clip position counter.
package scpc_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES     = 4096;
  localparam int unsigned DEF_MAX_PROBES        = 8;
  localparam int unsigned DEF_COUNT_BITS        = 16;
  localparam int unsigned DEF_KNOWN_CHROMOSOMES = 24;

  localparam logic [7:0]  RESET_MAPQ_FLOOR = 8'd10;
  localparam logic [15:0] RESET_SKIP_MASK  = 16'd1540;
  localparam logic [3:0]  OP_SOFT_CLIP     = 4'd4;

  // Halves of the 64-bit Fibonacci hashing multiplier.
  localparam logic [31:0] HASH_MULT_HI = 32'h9E3779B9;
  localparam logic [31:0] HASH_MULT_LO = 32'h7F4A7C15;

  typedef enum logic [1:0] {
    CMD_PROCESS = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_INDEX   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic {
    CFG_MAPQ_FLOOR = 1'b0,
    CFG_SKIP_MASK  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_LO,
    S_HASH_MID,
    S_HOME,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  chromosome;
    logic [30:0] read_position;
    logic [15:0] read_length;
    logic [15:0] read_flags;
    logic [7:0]  mapping_quality;
    logic [3:0]  first_cigar_op;
    logic [3:0]  last_cigar_op;
    logic [11:0] entry_index;
  } in_t;

  typedef struct packed {
    logic        read_counted;
    logic [1:0]  clip_sides;
    logic [15:0] start_clip_count;
    logic [15:0] end_clip_count;
    logic        entry_valid;
    logic [4:0]  entry_chrom;
    logic [31:0] entry_position;
    logic        table_full;
  } out_t;

  // Control from the sequencer to the hash unit.
  typedef struct packed {
    logic load_lo;
    logic load_mid;
  } hash_ctrl_t;

endpackage

>>> hdl/scpc_ram.sv
// Generic single-port synchronous RAM with a registered read.
module scpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/scpc_hash.sv
// Two-step multiplicative hash giving the home slot of a 37-bit key.
module scpc_hash
  import scpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                             clk,
  input  hash_ctrl_t                       ctrl,
  input  logic [36:0]                      key,
  output logic [$clog2(TABLE_ENTRIES)-1:0] home
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic [63:0] prod_lo;
  logic [31:0] prod_mid;
  logic [31:0] cross_a;
  logic [31:0] cross_b;
  logic [31:0] upper;

  // Only the low halves of the cross products reach bits 63:32 of the hash.
  assign cross_a = key[31:0] * HASH_MULT_HI;
  assign cross_b = {27'd0, key[36:32]} * HASH_MULT_LO;

  always_ff @(posedge clk) begin
    if (ctrl.load_lo) begin
      prod_lo <= {32'd0, key[31:0]} * {32'd0, HASH_MULT_LO};
    end
    if (ctrl.load_mid) begin
      prod_mid <= cross_a + cross_b;
    end
  end

  assign upper = prod_lo[63:32] + prod_mid;
  assign home  = upper[AW-1:0];

endmodule

>>> hdl/soft_clip_position_counter.sv
// Top level of the soft-clip position counter: sequencer, registers and hash table.
//
// Requests arrive on in_valid/in_stall with an in_t payload; every request gives
// exactly one result on out_valid/out_stall as an out_t payload. A request is
// taken when in_valid is high and in_stall is low, and the block works on one
// request at a time.
// A process request runs one hash-and-probe pass per soft clip. Each pass runs the
// hashing steps (two multiplier steps and the home slot load), then a read and a
// check and write-back of the single-port table RAM per probe. A lookup runs one
// such pass; an index read goes straight to a single table read. A dropped read,
// an index beyond the table and an unknown command go straight to the hand-over.
// Results go into an output register, so a stalled receiver holds a finished result
// there while the sequencer goes on; a later result waits in its hand-over state.
// After rst the table RAM is swept clean, one slot per cycle, over all TABLE_ENTRIES
// slots; in_stall stays high throughout. Configuration writes are taken at any
// time, and rst restores the registers to their defaults and clears table_full.
// TABLE_ENTRIES must be a power of two.
module soft_clip_position_counter
  import scpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES     = DEF_TABLE_ENTRIES,
  parameter int unsigned MAX_PROBES        = DEF_MAX_PROBES,
  parameter int unsigned COUNT_BITS        = DEF_COUNT_BITS,
  parameter int unsigned KNOWN_CHROMOSOMES = DEF_KNOWN_CHROMOSOMES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned PW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int unsigned CB = COUNT_BITS;
  // Slot word: valid, chromosome, position, start count, end count.
  localparam int unsigned EW = 1 + 37 + 2 * CB;
  // Wide enough to compare any entry_index with the table size.
  localparam int unsigned XW = ((AW > 12) ? AW : 12) + 1;

  // Registers.
  state_t          state, state_next;
  logic [AW-1:0]   clr_addr, clr_addr_next;
  cmd_t            cmd, cmd_next;
  logic [4:0]      key_chrom, key_chrom_next;
  logic [31:0]     key_pos, key_pos_next;
  logic [31:0]     end_pos, end_pos_next;
  logic            pend_end, pend_end_next;
  logic            side, side_next;
  logic [AW-1:0]   idx, idx_next;
  logic [PW-1:0]   probe, probe_next;
  logic            overflow, overflow_next;
  out_t            res, res_next;
  logic            out_valid_next;
  out_t            out_data_next;
  logic [7:0]      mapq_floor;
  logic [15:0]     skip_mask;

  // Memory and hash connections.
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;
  hash_ctrl_t      hash_ctrl;
  logic [AW-1:0]   home;

  // Fields of the slot just read.
  logic            rd_valid;
  logic [4:0]      rd_chrom;
  logic [31:0]     rd_pos;
  logic [CB-1:0]   rd_start;
  logic [CB-1:0]   rd_end;
  logic            rd_match;
  logic [CB-1:0]   new_start;
  logic [CB-1:0]   new_end;

  // Request decode.
  logic            read_pass;
  logic            clip_first;
  logic            clip_last;
  logic [31:0]     req_pos;
  logic [31:0]     req_end;
  logic [XW-1:0]   index_wide;
  logic            in_accept;
  logic            out_free;

  assign rd_valid = ram_rdata[EW-1];
  assign rd_chrom = ram_rdata[EW-2 -: 5];
  assign rd_pos   = ram_rdata[EW-7 -: 32];
  assign rd_start = ram_rdata[2*CB-1 -: CB];
  assign rd_end   = ram_rdata[CB-1:0];
  assign rd_match = rd_valid && (rd_chrom == key_chrom) && (rd_pos == key_pos);

  assign read_pass = ((in_data.read_flags & skip_mask) == 16'd0)
                     && (in_data.mapping_quality >= mapq_floor)
                     && (in_data.chromosome < 5'(KNOWN_CHROMOSOMES));
  assign clip_first = (in_data.first_cigar_op == OP_SOFT_CLIP);
  assign clip_last  = (in_data.last_cigar_op == OP_SOFT_CLIP);
  assign req_pos    = {1'b0, in_data.read_position};
  assign req_end    = req_pos + {16'd0, in_data.read_length};
  assign index_wide = XW'(in_data.entry_index);

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Counts clamp to 16 bits on output when the stored counts are wider.
  function automatic logic [15:0] clamp_count(input logic [CB-1:0] c);
    logic [CB+15:0] w;
    w = {16'd0, c};
    clamp_count = (w > (CB+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
    sat_inc = (c == {CB{1'b1}}) ? c : c + CB'(1);
  endfunction

  scpc_hash #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_hash (
    .clk  (clk),
    .ctrl (hash_ctrl),
    .key  ({key_chrom, key_pos}),
    .home (home)
  );

  scpc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mapq_floor <= RESET_MAPQ_FLOOR;
      skip_mask  <= RESET_SKIP_MASK;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAPQ_FLOOR: mapq_floor <= cfg_data[7:0];
        CFG_SKIP_MASK:  skip_mask  <= cfg_data;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    cmd_next       = cmd;
    key_chrom_next = key_chrom;
    key_pos_next   = key_pos;
    end_pos_next   = end_pos;
    pend_end_next  = pend_end;
    side_next      = side;
    idx_next       = idx;
    probe_next     = probe;
    overflow_next  = overflow;
    res_next       = res;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    hash_ctrl      = '0;
    ram_we         = 1'b0;
    ram_addr       = idx;
    ram_wdata      = '0;
    new_start      = '0;
    new_end        = '0;

    unique case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_addr      = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == {AW{1'b1}}) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          cmd_next       = cmd_t'(in_data.command);
          res_next       = '0;
          key_chrom_next = in_data.chromosome;
          key_pos_next   = req_pos;
          end_pos_next   = req_end;
          side_next      = 1'b0;
          pend_end_next  = 1'b0;
          probe_next     = '0;
          unique case (cmd_t'(in_data.command))
            CMD_PROCESS: begin
              res_next.read_counted = read_pass;
              res_next.clip_sides   = read_pass ? {clip_last, clip_first} : 2'b00;
              pend_end_next         = read_pass && clip_first && clip_last;
              if (read_pass && clip_first) begin
                state_next = S_HASH_LO;
              end else if (read_pass && clip_last) begin
                key_pos_next = req_end;
                side_next    = 1'b1;
                state_next   = S_HASH_LO;
              end else begin
                state_next = S_FINISH;
              end
            end
            CMD_LOOKUP: begin
              state_next = S_HASH_LO;
            end
            CMD_INDEX: begin
              idx_next   = index_wide[AW-1:0];
              state_next = (index_wide < XW'(TABLE_ENTRIES)) ? S_READ : S_FINISH;
            end
            CMD_NONE: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end

      S_HASH_LO: begin
        hash_ctrl.load_lo = 1'b1;
        state_next        = S_HASH_MID;
      end

      S_HASH_MID: begin
        hash_ctrl.load_mid = 1'b1;
        state_next         = S_HOME;
      end

      S_HOME: begin
        idx_next   = home;
        probe_next = '0;
        state_next = S_READ;
      end

      S_READ: begin
        state_next = S_CHECK;
      end

      S_CHECK: begin
        unique case (cmd)
          CMD_INDEX: begin
            if (rd_valid) begin
              res_next.start_clip_count = clamp_count(rd_start);
              res_next.end_clip_count   = clamp_count(rd_end);
              res_next.entry_valid      = 1'b1;
              res_next.entry_chrom      = rd_chrom;
              res_next.entry_position   = rd_pos;
            end
            state_next = S_FINISH;
          end

          CMD_LOOKUP: begin
            if (rd_match) begin
              res_next.start_clip_count = clamp_count(rd_start);
              res_next.end_clip_count   = clamp_count(rd_end);
              res_next.entry_valid      = 1'b1;
              res_next.entry_chrom      = key_chrom;
              res_next.entry_position   = key_pos;
              state_next                = S_FINISH;
            end else if (!rd_valid || probe == PW'(MAX_PROBES - 1)) begin
              state_next = S_FINISH;
            end else begin
              idx_next   = idx + AW'(1);
              probe_next = probe + PW'(1);
              state_next = S_READ;
            end
          end

          CMD_PROCESS: begin
            if (!rd_valid || rd_match || probe == PW'(MAX_PROBES - 1)) begin
              if (!rd_valid || rd_match) begin
                // A fresh slot starts from zero counts before the increment.
                new_start = rd_valid ? rd_start : '0;
                new_end   = rd_valid ? rd_end : '0;
                if (side) begin
                  new_end = sat_inc(new_end);
                end else begin
                  new_start = sat_inc(new_start);
                end
                ram_we    = 1'b1;
                ram_wdata = {1'b1, key_chrom, key_pos, new_start, new_end};
              end else begin
                overflow_next = 1'b1;
              end
              if (!side && pend_end) begin
                key_pos_next = end_pos;
                side_next    = 1'b1;
                state_next   = S_HASH_LO;
              end else begin
                state_next = S_FINISH;
              end
            end else begin
              idx_next   = idx + AW'(1);
              probe_next = probe + PW'(1);
              state_next = S_READ;
            end
          end

          CMD_NONE: begin
            state_next = S_FINISH;
          end
        endcase
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_next           = 1'b1;
          out_data_next            = res;
          out_data_next.table_full = overflow;
          state_next               = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      overflow  <= overflow_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    key_chrom <= key_chrom_next;
    key_pos   <= key_pos_next;
    end_pos   <= end_pos_next;
    pend_end  <= pend_end_next;
    side      <= side_next;
    idx       <= idx_next;
    probe     <= probe_next;
    res       <= res_next;
    out_data  <= out_data_next;
  end

  // The overflow flag is sticky: once reported it is reported on every later result.
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.table_full) ##1 out_valid
      |-> out_data.table_full)
    else $error("table_full fell without reset");

  // The table is written only by the clearing sweep or the check step.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_CHECK))
    else $error("table written outside sweep or check");

  // A counted read never reports entry fields.
  a_counted_no_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.read_counted) |-> !out_data.entry_valid)
    else $error("process result carries an entry");

  // No request is taken while the sweep runs.
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("request accepted during table sweep");

endmodule

>>> tb/soft_clip_position_counter_tb.sv
// Self-checking testbench of the soft-clip position counter.
`timescale 1ns / 1ps

module soft_clip_position_counter_tb;
  import scpc_pkg::*;

  localparam int SLOTS   = 4096;
  localparam int PROBES  = 8;
  localparam int CHROMS  = 24;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  soft_clip_position_counter u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  // Our own copy of the hash table and the register state.
  logic [36:0] mdl_key [SLOTS];
  logic        mdl_valid [SLOTS];
  logic [15:0] mdl_start [SLOTS];
  logic [15:0] mdl_end [SLOTS];
  logic        mdl_full;
  logic [7:0]  mdl_mapq_floor;
  logic [15:0] mdl_skip_mask;

  out_t expected_results[$];
  int   failures = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  function automatic int unsigned home_of(logic [36:0] key);
    logic [63:0] h;
    h = {27'd0, key} * 64'h9E3779B97F4A7C15;
    return h[43:32];
  endfunction

  // Find or insert a key and bump one of its counts, saturating.
  function automatic void count_clip(logic [36:0] key, bit end_side);
    int unsigned idx;
    idx = home_of(key);
    for (int p = 0; p < PROBES; p++) begin
      if (!mdl_valid[idx]) begin
        mdl_valid[idx] = 1'b1;
        mdl_key[idx] = key;
        mdl_start[idx] = '0;
        mdl_end[idx] = '0;
      end
      if (mdl_key[idx] == key) begin
        if (end_side) begin
          if (mdl_end[idx] != COUNT_TOP) mdl_end[idx]++;
        end else begin
          if (mdl_start[idx] != COUNT_TOP) mdl_start[idx]++;
        end
        return;
      end
      idx = (idx + 1) % SLOTS;
    end
    mdl_full = 1'b1;
  endfunction

  function automatic out_t clip_count_result(in_t rq);
    out_t r;
    logic [36:0] key;
    int unsigned idx;
    r = '0;
    case (cmd_t'(rq.command))
      CMD_PROCESS: begin
        if ((rq.read_flags & mdl_skip_mask) == 0 && rq.mapping_quality >= mdl_mapq_floor
            && rq.chromosome < CHROMS) begin
          r.read_counted = 1'b1;
          if (rq.first_cigar_op == OP_SOFT_CLIP) begin
            r.clip_sides[0] = 1'b1;
            count_clip({rq.chromosome, 1'b0, rq.read_position}, 1'b0);
          end
          if (rq.last_cigar_op == OP_SOFT_CLIP) begin
            r.clip_sides[1] = 1'b1;
            count_clip({rq.chromosome, {1'b0, rq.read_position} + 32'(rq.read_length)},
                       1'b1);
          end
        end
      end
      CMD_LOOKUP: begin
        key = {rq.chromosome, 1'b0, rq.read_position};
        idx = home_of(key);
        for (int p = 0; p < PROBES; p++) begin
          if (!mdl_valid[idx]) break;
          if (mdl_key[idx] == key) begin
            r.start_clip_count = mdl_start[idx];
            r.end_clip_count = mdl_end[idx];
            r.entry_valid = 1'b1;
            r.entry_chrom = rq.chromosome;
            r.entry_position = {1'b0, rq.read_position};
            break;
          end
          idx = (idx + 1) % SLOTS;
        end
      end
      CMD_INDEX: begin
        if (mdl_valid[rq.entry_index]) begin
          r.start_clip_count = mdl_start[rq.entry_index];
          r.end_clip_count = mdl_end[rq.entry_index];
          r.entry_valid = 1'b1;
          r.entry_chrom = mdl_key[rq.entry_index][36:32];
          r.entry_position = mdl_key[rq.entry_index][31:0];
        end
      end
      default: ;
    endcase
    r.table_full = mdl_full;
    return r;
  endfunction

  // Receiver: stalls at random and checks every accepted result.
  always @(negedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, out_data);
          failures++;
        end
      end
    end
  end

  // Present one request, with a random gap before it, and wait for its acceptance.
  // The request stays on the port after acceptance until the next call or an idle.
  task automatic send_request(in_t rq, bit has_want = 1'b0, out_t want = '0);
    out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = clip_count_result(rq);
    if (has_want && predicted !== want) begin
      $display("%0t: table row expected %h actual %h", $time, want, predicted);
      failures++;
    end
    expected_results.push_back(predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAPQ_FLOOR) mdl_mapq_floor = val[7:0];
    else mdl_skip_mask = val;
  endtask

  function automatic in_t read_req(logic [4:0] ch, logic [30:0] pos, logic [15:0] len,
                                   logic [3:0] f_op, logic [3:0] l_op);
    in_t rq;
    rq = '0;
    rq.command = CMD_PROCESS;
    rq.chromosome = ch;
    rq.read_position = pos;
    rq.read_length = len;
    rq.mapping_quality = 8'd60;
    rq.first_cigar_op = f_op;
    rq.last_cigar_op = l_op;
    return rq;
  endfunction

  typedef struct {
    in_t  rq;
    bit   has_want;
    out_t want;
  } row_t;

  initial begin
    row_t rows[$];
    in_t  rq;
    out_t w;
    logic [30:0] pos_pool[16];
    for (int i = 0; i < SLOTS; i++) mdl_valid[i] = 1'b0;
    mdl_full = 1'b0;
    mdl_mapq_floor = RESET_MAPQ_FLOOR;
    mdl_skip_mask = RESET_SKIP_MASK;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: fresh table looks, all commands, field extremes.
    rq = '0; rq.command = CMD_INDEX; rq.entry_index = 12'hFFF;
    rows.push_back('{rq, 1'b1, out_t'('0)});
    rq = '0; rq.command = CMD_LOOKUP; rq.read_position = '1; rq.chromosome = 5'd23;
    rows.push_back('{rq, 1'b1, out_t'('0)});
    rq = '1; rq.command = CMD_NONE;
    rows.push_back('{rq, 1'b1, out_t'('0)});
    // Unknown chromosome, masked flag and low quality are all dropped.
    rows.push_back('{read_req(5'd31, 31'd5, 16'd3, OP_SOFT_CLIP, OP_SOFT_CLIP),
                     1'b1, out_t'('0)});
    rq = read_req(5'd1, 31'd5, 16'd3, OP_SOFT_CLIP, 4'd0); rq.read_flags = 16'h0400;
    rows.push_back('{rq, 1'b1, out_t'('0)});
    rq = read_req(5'd1, 31'd5, 16'd3, OP_SOFT_CLIP, 4'd0); rq.mapping_quality = 8'd9;
    rows.push_back('{rq, 1'b1, out_t'('0)});
    w = '0; w.read_counted = 1'b1;
    rows.push_back('{read_req(5'd0, 31'd0, 16'd0, 4'd0, 4'hF), 1'b1, w});
    w.clip_sides = 2'b11;
    rows.push_back('{read_req(5'd23, '1, 16'hFFFF, OP_SOFT_CLIP, OP_SOFT_CLIP), 1'b1, w});
    // Same key twice with zero length, then look it up.
    rows.push_back('{read_req(5'd7, 31'd1000, 16'd0, OP_SOFT_CLIP, OP_SOFT_CLIP),
                     1'b0, out_t'('0)});
    rq = '0; rq.command = CMD_LOOKUP; rq.chromosome = 5'd7; rq.read_position = 31'd1000;
    rows.push_back('{rq, 1'b0, out_t'('0)});
    rq = '0; rq.command = CMD_LOOKUP; rq.chromosome = 5'd23; rq.read_position = '1;
    rows.push_back('{rq, 1'b0, out_t'('0)});
    for (int i = 0; i < 6; i++) begin
      rq = '0; rq.command = CMD_INDEX; rq.entry_index = 12'($urandom);
      rows.push_back('{rq, 1'b0, out_t'('0)});
    end
    foreach (rows[i]) send_request(rows[i].rq, rows[i].has_want, rows[i].want);

    // Random phases; registers change between phases, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 88; end
        2: begin send_idle_pct = 88; recv_idle_pct = 38; end
        4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        default: ;
      endcase
      case (phase)
        1: begin write_reg(CFG_MAPQ_FLOOR, 16'd0); write_reg(CFG_SKIP_MASK, 16'd0); end
        2: begin write_reg(CFG_MAPQ_FLOOR, 16'd255); write_reg(CFG_SKIP_MASK, 16'hFFFF); end
        3: begin write_reg(CFG_MAPQ_FLOOR, 16'd30); write_reg(CFG_SKIP_MASK, 16'h0F0F); end
        4: begin write_reg(CFG_MAPQ_FLOOR, 16'($urandom));
                  write_reg(CFG_SKIP_MASK, 16'($urandom) & 16'h00FF); end
        5: begin write_reg(CFG_MAPQ_FLOOR, 16'd10); write_reg(CFG_SKIP_MASK, 16'd1540); end
        default: ;
      endcase
      // A small pool of positions makes hits, collisions and saturation-free reuse.
      foreach (pos_pool[i]) pos_pool[i] = 31'($urandom);
      for (int n = 0; n < 100; n++) begin
        rq = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(3) != 0) rq.read_position = pos_pool[$urandom_range(15)];
        if ($urandom_range(3) != 0) rq.chromosome = 5'($urandom_range(3));
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: begin
            rq.command = CMD_PROCESS;
            if ($urandom_range(3) != 0) begin
              rq.read_flags &= ~mdl_skip_mask;
              rq.mapping_quality = 8'($urandom_range(255, mdl_mapq_floor));
              rq.read_length = 16'($urandom_range(3));
            end
            if ($urandom_range(2) != 0) rq.first_cigar_op = OP_SOFT_CLIP;
            if ($urandom_range(2) != 0) rq.last_cigar_op = OP_SOFT_CLIP;
          end
          6, 7: rq.command = CMD_LOOKUP;
          8: rq.command = CMD_INDEX;
          default: rq.command = ($urandom_range(1) != 0) ? CMD_NONE : CMD_INDEX;
        endcase
        send_request(rq);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog: clearing sweep plus 600 slow requests under heavy stalls, many times over.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
